@@ rtl/core/smrp_pkg.sv @@
// Shared types and constants of the stack command engine.
// Used by the cell, the remainder unit and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package smrp_pkg;

	localparam int CNT_W = 6;
	localparam int WORD_W = 32;
	localparam int DIV_CNT_W = 5;
	localparam logic [6:0] NEWLINE_CODE = 7'd10;
	localparam logic [6:0] CHAR_MAX_CODE = 7'd127;

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_MOD   = 3'd1,
		CMD_PCHAR = 3'd2,
		CMD_PSTR  = 3'd3,
		CMD_ROTL  = 3'd4,
		CMD_ROTR  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_FEW     = 3'd1,
		STS_DIVZERO = 3'd2,
		STS_EMPTY   = 3'd3,
		STS_RANGE   = 3'd4,
		STS_FULL    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_ROTL
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_ROT,
		S_PSTR,
		S_NL,
		S_FIN
	} state_t;

	typedef struct packed {
		cell_op_t           op;
		logic [WORD_W-1:0]  new_top;
		logic [CNT_W-1:0]   last_idx;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/smrp_cell.sv @@
// One stack cell: holds a single entry, with the top of the stack in cell zero.
// Depends on smrp_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module smrp_cell #(
	parameter int INDEX = 0
) (
	input  wire                          clk,
	input  smrp_pkg::cell_ctl_t          ctl,
	input  wire [smrp_pkg::WORD_W-1:0]   up_data,
	input  wire [smrp_pkg::WORD_W-1:0]   down_data,
	input  wire [smrp_pkg::WORD_W-1:0]   top_data,
	output logic [smrp_pkg::WORD_W-1:0]  data
);
	import smrp_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_PUSH: begin
				data_q <= (INDEX == 0) ? ctl.new_top : up_data;
			end
			OP_POP: begin
				data_q <= (INDEX == 0) ? ctl.new_top : down_data;
			end
			OP_ROTL: begin
				if (IDX == ctl.last_idx) begin
					data_q <= top_data;
				end else if (IDX < ctl.last_idx) begin
					data_q <= down_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule
`default_nettype wire

@@ rtl/core/smrp_rem.sv @@
// Iterative signed remainder unit, one restoring step per cycle.
// Depends on smrp_pkg for word and counter widths.
`timescale 1ns / 1ps
`default_nettype none
module smrp_rem (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [smrp_pkg::WORD_W-1:0]   dividend,
	input  wire [smrp_pkg::WORD_W-1:0]   divisor,
	output logic                         done,
	output logic [smrp_pkg::WORD_W-1:0]  rem
);
	import smrp_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    a_q;
	logic [WORD_W-1:0]    b_q;
	logic [WORD_W-1:0]    r_q;
	logic                 neg_q;
	logic [WORD_W:0]      shifted;
	logic [WORD_W:0]      diff;

	assign shifted = {r_q, a_q[WORD_W-1]};
	assign diff = shifted - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == '1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
			b_q <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
			neg_q <= dividend[WORD_W-1];
			r_q <= '0;
		end else if (run_q) begin
			a_q <= {a_q[WORD_W-2:0], 1'b0};
			r_q <= diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
		end
	end

	assign done = done_q;
	assign rem = neg_q ? (WORD_W'(0) - r_q) : r_q;

endmodule
`default_nettype wire

@@ rtl/core/stack_mod_rotate_print_engine.sv @@
// Top level of the stack command engine: command FSM, cell chain, remainder unit.
// Depends on smrp_pkg, smrp_cell and smrp_rem.
//
// Commands arrive on the s_ channel (value in s_tdata, command in s_tuser) and
// results leave on the m_ channel (status and character in m_tdata, the
// character flag in m_tuser, the end of a command's results in m_tlast).
// The stack is a row of cells with the top in cell zero; every stack
// operation moves all held entries by one place together.
// One command is worked on at a time; s_tready is high while no command is
// in progress, even if a result still waits in the output register.
// Push, rotate left, pchar and errors give their first result from the execute
// state; mod waits for the one-bit-per-cycle remainder unit; rotate right with
// N entries held rotates the cell chain N-1 times before its result; pstr
// rotates the chain N times, giving each printable character from the top
// until one does not print, and ends with a newline. When a result still waits
// in the output register and m_tready is low, the engine holds before its next
// result until the register frees up; no result is dropped. Reset empties the
// stack (count zero) and clears the output valid flag; entry contents are not
// cleared.
`timescale 1ns / 1ps
`default_nettype none
module stack_mod_rotate_print_engine #(
	parameter int STACK_DEPTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // value[31:0]
	input  wire  [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // status[2:0], char_code[9:3], zero[15:10]
	output logic [0:0]  m_tuser,   // char_valid[0]
	output logic        m_tlast
);
	import smrp_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [WORD_W-1:0] val_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] step_q, step_d;
	logic stop_q, stop_d;

	logic out_valid_q;
	status_t out_status_q;
	logic out_cv_q;
	logic [6:0] out_code_q;
	logic out_last_q;

	logic emit;
	status_t emit_status;
	logic emit_cv;
	logic [6:0] emit_code;
	logic emit_last;
	logic can_emit;

	cell_ctl_t ctl;
	logic [WORD_W-1:0] cell_data [STACK_DEPTH];
	logic [WORD_W-1:0] top;
	logic div_start;
	logic div_done;
	logic [WORD_W-1:0] div_rem;
	logic top_printable;
	logic top_char;
	logic s_xfer;

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			smrp_cell #(.INDEX(gi)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.up_data   (cell_data[(gi == 0) ? 0 : gi - 1]),
				.down_data (cell_data[(gi == STACK_DEPTH - 1) ? gi : gi + 1]),
				.top_data  (cell_data[0]),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	smrp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cell_data[1]),
		.divisor  (cell_data[0]),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign top = cell_data[0];
	assign top_char = (top[WORD_W-1:7] == '0);
	assign top_printable = top_char && (top[6:0] != 7'd0) && (top[6:0] != CHAR_MAX_CODE);
	assign can_emit = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign s_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q <= '0;
			stop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q <= step_d;
			stop_q <= stop_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cmd_q <= cmd_t'(s_tuser);
			val_q <= s_tdata;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_cv_q <= emit_cv;
			out_code_q <= emit_code;
			out_last_q <= emit_last;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		step_d = step_q;
		stop_d = stop_q;
		emit = 1'b0;
		emit_status = STS_OK;
		emit_cv = 1'b0;
		emit_code = 7'd0;
		emit_last = 1'b1;
		div_start = 1'b0;
		ctl.op = OP_HOLD;
		ctl.new_top = val_q;
		ctl.last_idx = count_q - CNT_W'(1);
		unique case (state_q)
			S_IDLE: begin
				if (s_xfer) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_PUSH: begin
						if (can_emit) begin
							emit = 1'b1;
							state_d = S_IDLE;
							if (count_q == DEPTH_C) begin
								emit_status = STS_FULL;
							end else begin
								ctl.op = OP_PUSH;
								count_d = count_q + CNT_W'(1);
							end
						end
					end
					CMD_MOD: begin
						if (count_q < CNT_W'(2)) begin
							if (can_emit) begin
								emit = 1'b1;
								emit_status = STS_FEW;
								state_d = S_IDLE;
							end
						end else if (top == '0) begin
							if (can_emit) begin
								emit = 1'b1;
								emit_status = STS_DIVZERO;
								state_d = S_IDLE;
							end
						end else begin
							div_start = 1'b1;
							state_d = S_DIV;
						end
					end
					CMD_PCHAR: begin
						if (can_emit) begin
							emit = 1'b1;
							if (count_q == '0) begin
								emit_status = STS_EMPTY;
								state_d = S_IDLE;
							end else if (!top_char) begin
								emit_status = STS_RANGE;
								state_d = S_IDLE;
							end else begin
								emit_cv = 1'b1;
								emit_code = top[6:0];
								emit_last = 1'b0;
								state_d = S_NL;
							end
						end
					end
					CMD_PSTR: begin
						step_d = '0;
						stop_d = 1'b0;
						state_d = S_PSTR;
					end
					CMD_ROTL: begin
						if (can_emit) begin
							emit = 1'b1;
							state_d = S_IDLE;
							if (count_q >= CNT_W'(2)) begin
								ctl.op = OP_ROTL;
							end
						end
					end
					CMD_ROTR: begin
						step_d = '0;
						state_d = (count_q >= CNT_W'(2)) ? S_ROT : S_FIN;
					end
					default: begin
						if (can_emit) begin
							emit = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					ctl.op = OP_POP;
					ctl.new_top = div_rem;
					count_d = count_q - CNT_W'(1);
					state_d = S_FIN;
				end
			end
			S_ROT: begin
				ctl.op = OP_ROTL;
				step_d = step_q + CNT_W'(1);
				if (step_q == count_q - CNT_W'(2)) begin
					state_d = S_FIN;
				end
			end
			S_PSTR: begin
				if (step_q == count_q) begin
					state_d = S_NL;
				end else if (!stop_q && top_printable) begin
					if (can_emit) begin
						emit = 1'b1;
						emit_cv = 1'b1;
						emit_code = top[6:0];
						emit_last = 1'b0;
						ctl.op = OP_ROTL;
						step_d = step_q + CNT_W'(1);
					end
				end else begin
					stop_d = 1'b1;
					ctl.op = OP_ROTL;
					step_d = step_q + CNT_W'(1);
				end
			end
			S_NL: begin
				if (can_emit) begin
					emit = 1'b1;
					emit_cv = 1'b1;
					emit_code = NEWLINE_CODE;
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				if (can_emit) begin
					emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_code_q, out_status_q};
	assign m_tuser = out_cv_q;
	assign m_tlast = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count exceeds depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
		else $error("stack count moved by more than one");

	a_div_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (count_q >= CNT_W'(2)))
		else $error("remainder running with fewer than two entries");

	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[2:0] == STS_OK))
		else $error("character result with error status");
`endif

endmodule
`default_nettype wire
